[src/nfsa_pkg.sv]
// Shared constants, types and helper functions for the next-fit slot allocator.
// Used by the controller, the datapath and the top level; depends on nothing.
package nfsa_pkg;

    localparam int SLOTS       = 4096;
    localparam int SLOT_W      = $clog2(SLOTS);
    localparam int BIT_W       = 6;
    localparam int ROW_BITS    = 1 << BIT_W;
    localparam int ROWS        = SLOTS / ROW_BITS;
    localparam int ROW_W       = SLOT_W - BIT_W;
    localparam int COUNT_W     = SLOT_W + 1;
    localparam int RESERVED    = 3;
    localparam int OP_W        = 2;
    localparam int IDX_W       = 13;
    localparam int KIND_W      = 3;
    localparam int WORD_W      = 32;
    localparam int STATUS_W    = 2;
    localparam int IN_TDATA_W  = 56;
    localparam int OUT_TDATA_W = 64;

    localparam logic [OP_W-1:0] OP_OPEN  = 2'd0;
    localparam logic [OP_W-1:0] OP_CLOSE = 2'd1;
    localparam logic [OP_W-1:0] OP_READ  = 2'd2;

    localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] ST_BAD_INDEX = 2'd1;
    localparam logic [STATUS_W-1:0] ST_INVALID   = 2'd2;
    localparam logic [STATUS_W-1:0] ST_FULL      = 2'd3;

    localparam logic [KIND_W-1:0] KIND_MIN      = 3'd1;
    localparam logic [KIND_W-1:0] KIND_MAX      = 3'd3;
    localparam logic [KIND_W-1:0] KIND_RESERVED = 3'd1;

    typedef logic [ROW_BITS-1:0] row_t;
    typedef logic [ROWS-1:0]     summary_t;

    localparam row_t RESV_MASK = row_t'((64'd1 << RESERVED) - 64'd1);

    typedef struct packed {
        logic latch;
        logic clear_step;
        logic do_error;
        logic do_eval1;
        logic do_search;
        logic do_eval2;
        logic load_out;
    } cmd_t;

    typedef struct packed {
        logic clear_done;
        logic err;
        logic is_open;
        logic hit;
        logic sum_found;
    } stat_t;

    // Returns {found, position} of the lowest set bit of a bitmap row.
    function automatic logic [BIT_W:0] first_bit(input row_t v);
        logic [BIT_W:0] r;
        r = '0;
        for (int i = ROW_BITS - 1; i >= 0; i--) begin
            if (v[i]) begin
                r = {1'b1, BIT_W'(i)};
            end
        end
        return r;
    endfunction

    // Returns {found, row} of the lowest set bit of the summary vector.
    function automatic logic [ROW_W:0] first_row(input summary_t v);
        logic [ROW_W:0] r;
        r = '0;
        for (int i = ROWS - 1; i >= 0; i--) begin
            if (v[i]) begin
                r = {1'b1, ROW_W'(i)};
            end
        end
        return r;
    endfunction

endpackage

[src/nfsa_ram.sv]
// Generic simple dual-port RAM with one write port and a registered read port.
// Standalone; used by the datapath for the bitmap, kind and payload stores.
module nfsa_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

[src/nfsa_ctrl.sv]
// Controller state machine of the slot allocator: sequences the clearing pass
// and each operation, and owns the beat handshakes. Depends on nfsa_pkg.
module nfsa_ctrl (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           s_tvalid,
    output logic           s_tready,
    output logic           m_tvalid,
    input  logic           m_tready,
    input  nfsa_pkg::stat_t stat,
    output nfsa_pkg::cmd_t  cmd
);
    import nfsa_pkg::*;

    localparam logic [2:0] S_CLEAR  = 3'd0;
    localparam logic [2:0] S_IDLE   = 3'd1;
    localparam logic [2:0] S_ISSUE  = 3'd2;
    localparam logic [2:0] S_EVAL   = 3'd3;
    localparam logic [2:0] S_SEARCH = 3'd4;
    localparam logic [2:0] S_EVAL2  = 3'd5;
    localparam logic [2:0] S_FIN    = 3'd6;

    logic [2:0] state_reg, state_next;
    logic       out_valid_reg, out_valid_next;

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = out_valid_reg;

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            S_CLEAR: begin
                cmd.clear_step = 1'b1;
                if (stat.clear_done) begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE: begin
                if (s_tvalid) begin
                    cmd.latch  = 1'b1;
                    state_next = S_ISSUE;
                end
            end
            S_ISSUE: begin
                if (stat.err) begin
                    cmd.do_error = 1'b1;
                    state_next   = S_FIN;
                end else begin
                    state_next = S_EVAL;
                end
            end
            S_EVAL: begin
                cmd.do_eval1 = 1'b1;
                if (!stat.is_open || stat.hit) begin
                    state_next = S_FIN;
                end else begin
                    state_next = S_SEARCH;
                end
            end
            S_SEARCH: begin
                cmd.do_search = 1'b1;
                state_next    = stat.sum_found ? S_EVAL2 : S_FIN;
            end
            S_EVAL2: begin
                cmd.do_eval2 = 1'b1;
                state_next   = S_FIN;
            end
            S_FIN: begin
                if (!out_valid_reg || m_tready) begin
                    cmd.load_out = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: begin
                state_next = S_CLEAR;
            end
        endcase
    end

    always_comb begin
        out_valid_next = out_valid_reg;
        if (cmd.load_out) begin
            out_valid_next = 1'b1;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_CLEAR;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

[src/nfsa_dp.sv]
// Datapath of the slot allocator: occupancy bitmap with a row summary, kind and
// payload stores, counters and result registers. Depends on nfsa_pkg, nfsa_ram.
module nfsa_dp (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  nfsa_pkg::cmd_t                      cmd,
    output nfsa_pkg::stat_t                     stat,
    input  logic [nfsa_pkg::IN_TDATA_W-1:0]     s_tdata,
    output logic [nfsa_pkg::OUT_TDATA_W-1:0]    m_tdata
);
    import nfsa_pkg::*;

    logic [OP_W-1:0]     op_reg, op_next;
    logic [IDX_W-1:0]    idx_reg, idx_next;
    logic [KIND_W-1:0]   type_reg, type_next;
    logic [WORD_W-1:0]   pay_reg, pay_next;
    logic [ROW_W-1:0]    cur_row_reg, cur_row_next;
    logic [ROW_W-1:0]    clr_row_reg, clr_row_next;
    summary_t            summary_reg, summary_next;
    logic [RESERVED-1:0] resv_reg, resv_next;
    logic [COUNT_W-1:0]  count_reg, count_next;
    logic [SLOT_W-1:0]   ptr_reg, ptr_next;

    logic [STATUS_W-1:0]    res_status_reg, res_status_next;
    logic [SLOT_W-1:0]      res_slot_reg, res_slot_next;
    logic [KIND_W-1:0]      res_type_reg, res_type_next;
    logic [WORD_W-1:0]      res_pay_reg, res_pay_next;
    logic [OUT_TDATA_W-1:0] out_reg, out_next;

    logic              bm_we;
    logic [ROW_W-1:0]  bm_waddr, bm_raddr;
    row_t              bm_wdata, bm_rdata;
    logic [KIND_W-1:0] kind_rdata;
    logic [WORD_W-1:0] pay_rdata;
    logic              store_we;
    logic [SLOT_W-1:0] new_slot;

    row_t              low_mask, avail, new_row;
    logic [BIT_W:0]    hit_r;
    summary_t          le_mask;
    logic [ROW_W:0]    above_r, wrap_r;
    logic [ROW_W-1:0]  tgt_row;
    logic              not_full, sum_found, commit, slot_bit, resv_hit;

    assign low_mask  = (row_t'(1) << ptr_reg[BIT_W-1:0]) - row_t'(1);
    assign avail     = ~bm_rdata & (cmd.do_eval2 ? '1 : ~low_mask);
    assign hit_r     = first_bit(avail);
    assign new_slot  = {cur_row_reg, hit_r[BIT_W-1:0]};
    assign new_row   = bm_rdata | (row_t'(1) << hit_r[BIT_W-1:0]);
    assign le_mask   = ~((~summary_t'(0) << cur_row_reg) << 1);
    assign above_r   = first_row(~(summary_reg | le_mask));
    assign wrap_r    = first_row(~summary_reg);
    assign not_full  = (count_reg != COUNT_W'(SLOTS));
    assign sum_found = above_r[ROW_W] || (wrap_r[ROW_W] && not_full);
    assign tgt_row   = above_r[ROW_W] ? above_r[ROW_W-1:0] : wrap_r[ROW_W-1:0];
    assign slot_bit  = bm_rdata[idx_reg[BIT_W-1:0]];
    assign commit    = (op_reg == OP_OPEN) && ((cmd.do_eval1 && hit_r[BIT_W]) || cmd.do_eval2);
    assign store_we  = commit;
    assign bm_raddr  = cmd.do_search ? tgt_row : cur_row_reg;

    always_comb begin
        resv_hit = 1'b0;
        for (int i = 0; i < RESERVED; i++) begin
            if (idx_reg[SLOT_W-1:0] == SLOT_W'(i) && resv_reg[i]) begin
                resv_hit = 1'b1;
            end
        end
    end

    assign stat.clear_done = (clr_row_reg == ROW_W'(ROWS - 1));
    assign stat.err        = (op_reg == OP_OPEN)
                             ? (type_reg < KIND_MIN || type_reg > KIND_MAX)
                             : ((op_reg != OP_CLOSE && op_reg != OP_READ) || idx_reg[IDX_W-1]);
    assign stat.is_open    = (op_reg == OP_OPEN);
    assign stat.hit        = hit_r[BIT_W];
    assign stat.sum_found  = sum_found;

    always_comb begin
        op_next         = op_reg;
        idx_next        = idx_reg;
        type_next       = type_reg;
        pay_next        = pay_reg;
        cur_row_next    = cur_row_reg;
        clr_row_next    = clr_row_reg;
        summary_next    = summary_reg;
        resv_next       = resv_reg;
        count_next      = count_reg;
        ptr_next        = ptr_reg;
        res_status_next = res_status_reg;
        res_slot_next   = res_slot_reg;
        res_type_next   = res_type_reg;
        res_pay_next    = res_pay_reg;
        out_next        = out_reg;
        bm_we           = 1'b0;
        bm_waddr        = cur_row_reg;
        bm_wdata        = bm_rdata;

        if (cmd.clear_step) begin
            bm_we        = 1'b1;
            bm_waddr     = clr_row_reg;
            bm_wdata     = (clr_row_reg == '0) ? RESV_MASK : '0;
            clr_row_next = clr_row_reg + ROW_W'(1);
        end

        if (cmd.latch) begin
            op_next      = s_tdata[1:0];
            idx_next     = s_tdata[14:2];
            type_next    = s_tdata[17:15];
            pay_next     = s_tdata[49:18];
            cur_row_next = (s_tdata[1:0] == OP_OPEN) ? ptr_reg[SLOT_W-1:BIT_W]
                                                     : s_tdata[SLOT_W+1:BIT_W+2];
        end

        if (cmd.do_error) begin
            res_status_next = (op_reg == OP_READ) ? ST_BAD_INDEX : ST_INVALID;
            res_slot_next   = (op_reg == OP_CLOSE || op_reg == OP_READ)
                              ? idx_reg[SLOT_W-1:0] : '0;
            res_type_next   = '0;
            res_pay_next    = '0;
        end

        if (commit) begin
            bm_we                     = 1'b1;
            bm_wdata                  = new_row;
            summary_next[cur_row_reg] = &new_row;
            ptr_next                  = new_slot;
            count_next                = count_reg + COUNT_W'(1);
            for (int i = 0; i < RESERVED; i++) begin
                if (new_slot == SLOT_W'(i)) begin
                    resv_next[i] = 1'b0;
                end
            end
            res_status_next = ST_OK;
            res_slot_next   = new_slot;
            res_type_next   = '0;
            res_pay_next    = '0;
        end

        if (cmd.do_eval1 && op_reg == OP_CLOSE) begin
            if (slot_bit) begin
                bm_we                     = 1'b1;
                bm_wdata                  = bm_rdata & ~(row_t'(1) << idx_reg[BIT_W-1:0]);
                summary_next[cur_row_reg] = 1'b0;
                if (count_reg != '0) begin
                    count_next = count_reg - COUNT_W'(1);
                end
                for (int i = 0; i < RESERVED; i++) begin
                    if (idx_reg[SLOT_W-1:0] == SLOT_W'(i)) begin
                        resv_next[i] = 1'b0;
                    end
                end
            end
            res_status_next = ST_OK;
            res_slot_next   = idx_reg[SLOT_W-1:0];
            res_type_next   = '0;
            res_pay_next    = '0;
        end

        if (cmd.do_eval1 && op_reg == OP_READ) begin
            res_status_next = ST_OK;
            res_slot_next   = idx_reg[SLOT_W-1:0];
            if (!slot_bit) begin
                res_type_next = '0;
                res_pay_next  = '0;
            end else if (resv_hit) begin
                res_type_next = KIND_RESERVED;
                res_pay_next  = '0;
            end else begin
                res_type_next = kind_rdata;
                res_pay_next  = pay_rdata;
            end
        end

        if (cmd.do_search) begin
            if (sum_found) begin
                cur_row_next = tgt_row;
            end else begin
                res_status_next = ST_FULL;
                res_slot_next   = '0;
                res_type_next   = '0;
                res_pay_next    = '0;
            end
        end

        if (cmd.load_out) begin
            out_next = {2'b00, count_reg, res_pay_reg, res_type_reg,
                        res_slot_reg, res_status_reg};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clr_row_reg <= '0;
            summary_reg <= '0;
            resv_reg    <= '1;
            count_reg   <= COUNT_W'(RESERVED);
            ptr_reg     <= SLOT_W'(RESERVED - 1);
        end else begin
            clr_row_reg <= clr_row_next;
            summary_reg <= summary_next;
            resv_reg    <= resv_next;
            count_reg   <= count_next;
            ptr_reg     <= ptr_next;
        end
    end

    always_ff @(posedge aclk) begin
        op_reg         <= op_next;
        idx_reg        <= idx_next;
        type_reg       <= type_next;
        pay_reg        <= pay_next;
        cur_row_reg    <= cur_row_next;
        res_status_reg <= res_status_next;
        res_slot_reg   <= res_slot_next;
        res_type_reg   <= res_type_next;
        res_pay_reg    <= res_pay_next;
        out_reg        <= out_next;
    end

    assign m_tdata = out_reg;

    nfsa_ram #(.WIDTH(ROW_BITS), .DEPTH(ROWS)) u_bitmap (
        .aclk  (aclk),
        .we    (bm_we),
        .waddr (bm_waddr),
        .wdata (bm_wdata),
        .raddr (bm_raddr),
        .rdata (bm_rdata)
    );

    nfsa_ram #(.WIDTH(KIND_W), .DEPTH(SLOTS)) u_kind (
        .aclk  (aclk),
        .we    (store_we),
        .waddr (new_slot),
        .wdata (type_reg),
        .raddr (idx_reg[SLOT_W-1:0]),
        .rdata (kind_rdata)
    );

    nfsa_ram #(.WIDTH(WORD_W), .DEPTH(SLOTS)) u_payload (
        .aclk  (aclk),
        .we    (store_we),
        .waddr (new_slot),
        .wdata (pay_reg),
        .raddr (idx_reg[SLOT_W-1:0]),
        .rdata (pay_rdata)
    );

endmodule

[src/next_fit_slot_allocator.sv]
// A read, a close or an open that finds a slot in the pointer's bitmap row goes through
// the issue, evaluate and finish states; an open that needs the row summary search adds
// the search and second evaluate states (only search when full); a rejected request goes
// from issue to finish. One item is in work at a time; m_tready can stall it in finish.
// Reset is synchronous and active low; afterwards a pass clears the
// occupancy bitmap, one row per cycle, with s_tready held low.
module next_fit_slot_allocator (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // opcode[1:0], slot_index[14:2], entry_type[17:15], entry_payload[49:18]
    input  logic [nfsa_pkg::IN_TDATA_W-1:0]     s_tdata,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // status[1:0], slot_out[13:2], type_out[16:14], payload_out[48:17],
    // in_use_count[61:49]
    output logic [nfsa_pkg::OUT_TDATA_W-1:0]    m_tdata
);
    import nfsa_pkg::*;

    cmd_t  cmd;
    stat_t stat;

    nfsa_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    nfsa_dp u_dp (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cmd     (cmd),
        .stat    (stat),
        .s_tdata (s_tdata),
        .m_tdata (m_tdata)
    );

endmodule
